FILE: rtl/smie_pkg.sv
// Shared types and constants for the stack machine instruction executor.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package smie_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int DATA_W      = 32;
    localparam int PAY_W       = 30;
    localparam int CMD_W       = 2;
    localparam int DEPTH_W     = 9;
    localparam int STATUS_W    = 2;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // instruction headers
    localparam logic [CMD_W-1:0] CMD_PUSH_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRIM_A = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_B = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PRIM_B = 2'd3;

    // primitive codes carried in the payload
    localparam logic [PAY_W-1:0] PRIM_HALT = 30'd0;
    localparam logic [PAY_W-1:0] PRIM_ADD  = 30'd1;
    localparam logic [PAY_W-1:0] PRIM_SUB  = 30'd2;
    localparam logic [PAY_W-1:0] PRIM_MUL  = 30'd3;
    localparam logic [PAY_W-1:0] PRIM_DIV  = 30'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic    load_instr;
        logic    push;
        logic    mem_read;
        logic    arith_write;
        logic    div_start;
        logic    div_write;
        logic    set_halt;
        logic    out_load;
        status_t status;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_push;
        logic is_halt;
        logic is_arith;
        logic is_div;
        logic halted;
        logic full;
        logic short_stack;
        logic divisor_zero;
        logic div_done;
    } dp_stat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  top_value;
        logic        [DEPTH_W-1:0] depth;
        logic                      halted;
        logic        [STATUS_W-1:0] status;
    } result_t;

endpackage

FILE: rtl/smie_if.sv
// Valid/ready channel interfaces: instruction words in, result words out.
// Depends on smie_pkg.
`timescale 1ns / 1ps

interface smie_instr_if;
    import smie_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [PAY_W-1:0]   payload;

    modport source (output valid, output command, output payload, input ready);
    modport sink   (input valid, input command, input payload, output ready);
endinterface

interface smie_result_if;
    import smie_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [DATA_W-1:0]   top_value;
    logic        [DEPTH_W-1:0]  depth;
    logic                       halted;
    logic        [STATUS_W-1:0] status;

    modport source (output valid, output top_value, output depth, output halted,
                    output status, input ready);
    modport sink   (input valid, input top_value, input depth, input halted,
                    input status, output ready);
endinterface

FILE: rtl/smie_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on smie_pkg.
`timescale 1ns / 1ps

module smie_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [smie_pkg::DATA_W-1:0] dividend,
    input  logic [smie_pkg::DATA_W-1:0] divisor,
    output logic                      done,
    output logic [smie_pkg::DATA_W-1:0] quotient
);
    import smie_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [DATA_W:0]   trial;
    logic              a_neg, b_neg;

    assign a_neg = dividend[DATA_W-1];
    assign b_neg = divisor[DATA_W-1];
    assign trial = {1'b0, rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]} - {1'b0, dvs_reg}
                   + {rem_reg[DATA_W-1], {DATA_W{1'b0}}};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = a_neg ? (DATA_W'(0) - dividend) : dividend;
            dvs_next  = b_neg ? (DATA_W'(0) - divisor) : divisor;
            neg_next  = a_neg ^ b_neg;
        end
        else if (busy_reg)
        begin
            // shift in next dividend bit, keep the trial difference if it fits
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

FILE: rtl/smie_dp.sv
// Datapath: instruction latch, stack memory with top-of-stack register,
// ALU, divider and result register. Depends on smie_pkg and smie_div.
`timescale 1ns / 1ps

module smie_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [smie_pkg::CMD_W-1:0] command,
    input  logic [smie_pkg::PAY_W-1:0] payload,
    input  smie_pkg::dp_cmd_t          cmd,
    output smie_pkg::dp_stat_t         stat,
    output smie_pkg::result_t          result
);
    import smie_pkg::*;

    logic [DATA_W-1:0] mem [STACK_DEPTH];

    logic [CMD_W-1:0]  cmd_reg;
    logic [PAY_W-1:0]  pay_reg;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              halt_reg, halt_next;
    logic [DATA_W-1:0] rd_data_reg;
    result_t           result_reg;

    logic              is_push;
    logic              mem_we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [DATA_W-1:0] alu;
    logic [DATA_W-1:0] quotient;
    logic              div_done;

    assign is_push = (cmd_reg == CMD_PUSH_A) || (cmd_reg == CMD_PUSH_B);

    always_comb
    begin
        stat.is_push      = is_push;
        stat.is_halt      = !is_push && (pay_reg == PRIM_HALT);
        stat.is_arith     = !is_push && (pay_reg inside {[PRIM_ADD:PRIM_DIV]});
        stat.is_div       = pay_reg == PRIM_DIV;
        stat.halted       = halt_reg;
        stat.full         = count_reg == CNT_W'(STACK_DEPTH);
        stat.short_stack  = count_reg < CNT_W'(2);
        stat.divisor_zero = top_reg == '0;
        stat.div_done     = div_done;
    end

    // entries below the top live in memory; the top itself is top_reg
    assign mem_we = cmd.push && (count_reg != '0);
    assign waddr  = ADDR_W'(count_reg - CNT_W'(1));
    assign raddr  = ADDR_W'(count_reg - CNT_W'(2));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= top_reg;
        if (cmd.mem_read)
            rd_data_reg <= mem[raddr];
    end

    always_comb
    begin
        case (pay_reg)
            PRIM_ADD: alu = rd_data_reg + top_reg;
            PRIM_SUB: alu = rd_data_reg - top_reg;
            PRIM_MUL: alu = rd_data_reg * top_reg;
            default:  alu = rd_data_reg;
        endcase
    end

    smie_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_data_reg),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        top_next   = top_reg;
        count_next = count_reg;
        halt_next  = halt_reg;
        if (cmd.push)
        begin
            top_next   = {{(DATA_W-PAY_W){1'b0}}, pay_reg};
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.arith_write)
        begin
            top_next   = alu;
            count_next = count_reg - CNT_W'(1);
        end
        else if (cmd.div_write)
        begin
            top_next   = quotient;
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.set_halt)
            halt_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            halt_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            halt_reg  <= halt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (cmd.load_instr)
        begin
            cmd_reg <= command;
            pay_reg <= payload;
        end
        if (cmd.out_load)
        begin
            result_reg.top_value <= (count_reg != '0) ? $signed(top_reg) : '0;
            result_reg.depth     <= DEPTH_W'(count_reg);
            result_reg.halted    <= halt_reg;
            result_reg.status    <= cmd.status;
        end
    end

    assign result = result_reg;

endmodule

FILE: rtl/smie_ctrl.sv
// Sequencing FSM: input handshake, decode decisions, divider wait, result handoff.
// Depends on smie_pkg.
`timescale 1ns / 1ps

module smie_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  smie_pkg::dp_stat_t stat,
    output smie_pkg::dp_cmd_t  cmd
);
    import smie_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_EXEC   = 5'b00100,
        S_DIV    = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t  state_reg, state_next;
    status_t status_reg, status_next;
    logic    out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.status     = status_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_instr = 1'b1;
                    status_next    = ST_OK;
                    state_next     = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                if (stat.halted)
                    status_next = ST_OK;
                else if (stat.is_push)
                begin
                    if (stat.full)
                        status_next = ST_OVER;
                    else
                        cmd.push = 1'b1;
                end
                else if (stat.is_halt)
                    cmd.set_halt = 1'b1;
                else if (stat.is_arith)
                begin
                    if (stat.short_stack)
                        status_next = ST_UNDER;
                    else if (stat.is_div && stat.divisor_zero)
                        status_next = ST_DIVZ;
                    else
                    begin
                        cmd.mem_read = 1'b1;
                        state_next   = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                if (stat.is_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.arith_write = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_write = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/stack_machine_instruction_executor_top.sv
// Stack machine instruction executor: top level.
// Sequence: push, halt and faulted words go IDLE, DECODE, DONE; add, sub and mul add
// EXEC; divide goes EXEC, then DIV while the one-bit-per-cycle divider runs its 32 steps.
// Throughput: one word at a time; the next word is accepted once the controller is back
// in IDLE, and DONE waits while the result slot is still full and not taken.
// Reset (rst_n, async, active low) empties the stack, clears halt and the result slot.
// Depends on smie_pkg, smie_if, smie_ctrl, smie_dp.
`timescale 1ns / 1ps

module stack_machine_instruction_executor_top (
    input  logic           clk,
    input  logic           rst_n,
    smie_instr_if.sink     instr,
    smie_result_if.source  result
);
    import smie_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    result_t  res;
    logic     in_ready;
    logic     out_valid;

    // Controller: sequences decode, the stack memory read, the divider and the
    // hand-off into the result register. The result register frees the
    // controller to take the next word while a result waits downstream.
    smie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (instr.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: stack storage (top of stack held in a register, the rest in
    // a single-port-write / registered-read memory), ALU, divider, result register.
    smie_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .command (instr.command),
        .payload (instr.payload),
        .cmd     (cmd),
        .stat    (stat),
        .result  (res)
    );

    assign instr.ready      = in_ready;
    assign result.valid     = out_valid;
    assign result.top_value = res.top_value;
    assign result.depth     = res.depth;
    assign result.halted    = res.halted;
    assign result.status    = res.status;

endmodule

FILE: tb/smie_checker.sv
// Checker for the stack machine instruction executor: keeps a shadow stack,
// predicts one result word per accepted instruction word and compares in order.
// Depends on smie_pkg; watches the channel signals only.
`timescale 1ns / 1ps

module smie_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 instr_valid,
    input  logic                                 instr_ready,
    input  logic [smie_pkg::CMD_W-1:0]           instr_command,
    input  logic [smie_pkg::PAY_W-1:0]           instr_payload,
    input  logic                                 result_valid,
    input  logic                                 result_ready,
    input  logic signed [smie_pkg::DATA_W-1:0]   result_top_value,
    input  logic [smie_pkg::DEPTH_W-1:0]         result_depth,
    input  logic                                 result_halted,
    input  logic [smie_pkg::STATUS_W-1:0]        result_status,
    output int                                   fail_count,
    output int                                   outstanding
);
    import smie_pkg::*;

    localparam int PRINT_CAP = 40;

    logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
    int                shadow_depth;
    logic              shadow_halted;
    result_t           pending_results [$];
    int                words_checked;

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("mismatch: %s on result word %0d, got %h, want %h",
                     field, words_checked, got, want);
    endtask

    // one instruction applied to the shadow machine; returns the word it reports
    function automatic result_t execute_instruction(input logic [CMD_W-1:0] cmd,
                                                    input logic [PAY_W-1:0] pay);
        result_t           word;
        status_t           st;
        logic [DATA_W-1:0] lhs, rhs, res, mag_l, mag_r;
        st  = ST_OK;
        res = '0;
        if (!shadow_halted)
        begin
            if (cmd == CMD_PUSH_A || cmd == CMD_PUSH_B)
            begin
                if (shadow_depth >= STACK_DEPTH)
                    st = ST_OVER;
                else
                begin
                    shadow_stack[shadow_depth] = DATA_W'(pay);
                    shadow_depth++;
                end
            end
            else if (pay == PRIM_HALT)
            begin
                shadow_halted = 1'b1;
            end
            else if (pay <= PRIM_DIV)
            begin
                if (shadow_depth < 2)
                    st = ST_UNDER;
                else
                begin
                    lhs = shadow_stack[shadow_depth-2];
                    rhs = shadow_stack[shadow_depth-1];
                    case (pay)
                        PRIM_ADD: res = lhs + rhs;
                        PRIM_SUB: res = lhs - rhs;
                        PRIM_MUL: res = lhs * rhs;
                        PRIM_DIV:
                        begin
                            if (rhs == '0)
                                st = ST_DIVZ;
                            else
                            begin
                                // magnitudes, then sign: truncates toward zero, MIN/-1 wraps
                                mag_l = lhs[DATA_W-1] ? -lhs : lhs;
                                mag_r = rhs[DATA_W-1] ? -rhs : rhs;
                                res   = mag_l / mag_r;
                                if (lhs[DATA_W-1] != rhs[DATA_W-1])
                                    res = -res;
                            end
                        end
                        default: ;
                    endcase
                    if (st == ST_OK)
                    begin
                        shadow_stack[shadow_depth-2] = res;
                        shadow_depth--;
                    end
                end
            end
        end
        word.top_value = (shadow_depth > 0) ? shadow_stack[shadow_depth-1] : '0;
        word.depth     = DEPTH_W'(shadow_depth);
        word.halted    = shadow_halted;
        word.status    = st;
        return word;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            pending_results.delete();
            shadow_depth  = 0;
            shadow_halted = 1'b0;
            fail_count    = 0;
            words_checked = 0;
            outstanding  <= 0;
        end
        else
        begin
            if (instr_valid && instr_ready)
                pending_results.push_back(execute_instruction(instr_command, instr_payload));
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected word", result_top_value, '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (result_top_value !== want.top_value)
                        report_mismatch("top_value", result_top_value, want.top_value);
                    if (result_depth !== want.depth)
                        report_mismatch("depth", DATA_W'(result_depth), DATA_W'(want.depth));
                    if (result_halted !== want.halted)
                        report_mismatch("halted", DATA_W'(result_halted),
                                        DATA_W'(want.halted));
                    if (result_status !== want.status)
                        report_mismatch("status", DATA_W'(result_status),
                                        DATA_W'(want.status));
                end
                words_checked++;
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

FILE: tb/tb.sv
// Testbench top for the stack machine instruction executor: clock, reset,
// instruction stimulus, result back-pressure, watchdog and verdict.
// Depends on smie_pkg, smie_if, stack_machine_instruction_executor_top, smie_checker.
`timescale 1ns / 1ps

module tb;
    import smie_pkg::*;

    localparam int              IDLE_LIMIT  = 2000;  // cycles with no word moving
    localparam int              HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int              TAIL_CYCLES = 40;    // divide latency plus margin
    localparam logic [PAY_W-1:0] PAY_MAX    = {PAY_W{1'b1}};

    // how strongly a stretch of random words leans towards pushes
    typedef enum int {MIX_GROW, MIX_EVEN, MIX_SHRINK} mix_t;

    logic clk;
    logic rst_n;

    smie_instr_if  instr_ch ();
    smie_result_if result_ch ();

    int fail_count;
    int outstanding;

    // shared between sender and receiver: no gaps while set; hold-off request
    bit quiet_mode;
    bit hold_request;

    stack_machine_instruction_executor_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (result_ch)
    );

    smie_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .instr_valid      (instr_ch.valid),
        .instr_ready      (instr_ch.ready),
        .instr_command    (instr_ch.command),
        .instr_payload    (instr_ch.payload),
        .result_valid     (result_ch.valid),
        .result_ready     (result_ch.ready),
        .result_top_value (result_ch.top_value),
        .result_depth     (result_ch.depth),
        .result_halted    (result_ch.halted),
        .result_status    (result_ch.status),
        .fail_count       (fail_count),
        .outstanding      (outstanding)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 0;
    end

    // Watchdog: a hang shows as a long run of cycles in which no word moves
    // on either side. The hold-off is well inside the limit.
    int idle_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one instruction word after a random gap, or none in quiet mode; return at the edge it is taken.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [PAY_W-1:0] pay);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            instr_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        instr_ch.valid   <= 1'b1;
        instr_ch.command <= cmd;
        instr_ch.payload <= pay;
        do @(posedge clk); while (!instr_ch.ready);
    endtask

    // Operand values: small ones give zeros for divide by zero, others spread over
    // every payload bit or over 0 to 255, with the extremes now and then.
    function automatic logic [PAY_W-1:0] rand_operand();
        case ($urandom_range(0, 3))
            0: return PAY_W'($urandom_range(0, 3));
            1: return PAY_W'($urandom);
            2: return $urandom_range(0, 1) ? PAY_MAX : '0;
            default: return PAY_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] push_header();
        return $urandom_range(0, 1) ? CMD_PUSH_A : CMD_PUSH_B;
    endfunction

    function automatic logic [CMD_W-1:0] prim_header();
        return $urandom_range(0, 1) ? CMD_PRIM_A : CMD_PRIM_B;
    endfunction

    // One random word; never a halt, which would end the useful part of the run.
    task automatic send_random_word(input mix_t mix);
        int               push_pct;
        logic [PAY_W-1:0] code;
        push_pct = (mix == MIX_GROW) ? 75 : (mix == MIX_SHRINK) ? 25 : 50;
        if ($urandom_range(0, 99) < push_pct)
            send_word(push_header(), rand_operand());
        else
        begin
            if ($urandom_range(0, 99) < 85)
                code = PAY_W'($urandom_range(32'(PRIM_ADD), 32'(PRIM_DIV)));
            else
                code = PAY_W'($urandom_range(32'(PRIM_DIV) + 32'd1, 32'(PAY_MAX)));  // unknown code
            send_word(prim_header(), code);
        end
    endtask

    // Stretches of random length, each with its own push bias and gap setting.
    task automatic run_random(input int count);
        int   sent;
        int   len;
        mix_t mix;
        sent = 0;
        while (sent < count)
        begin
            len        = $urandom_range(10, 60);
            mix        = mix_t'($urandom_range(0, 2));
            quiet_mode = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len && sent < count; i++)
            begin
                send_random_word(mix);
                sent++;
            end
        end
    endtask

    // Stop offering and wait for the checker to have nothing in flight.
    task automatic wait_drained();
        instr_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Receiver: random gap before each result word, now and then none,
    // and one long hold-off while the sender keeps offering.
    initial
    begin
        int gap;
        result_ch.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                gap          = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
                gap = quiet_mode ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    // Sender: reset, directed words, random phases, halt and words after it, verdict.
    initial
    begin
        rst_n            = 1'b0;
        instr_ch.valid   = 1'b0;
        instr_ch.command = CMD_PUSH_A;
        instr_ch.payload = '0;
        quiet_mode       = 1'b0;
        hold_request     = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: faults on a short stack, divide by zero, unknown codes
        send_word(CMD_PRIM_A, PRIM_ADD);          // empty stack, underflow
        send_word(CMD_PUSH_A, PAY_MAX);
        send_word(CMD_PRIM_B, PRIM_SUB);          // one entry, underflow
        send_word(CMD_PUSH_B, '0);
        send_word(CMD_PRIM_A, PRIM_DIV);          // divisor zero
        send_word(CMD_PRIM_A, PAY_MAX);           // unknown code, widest
        send_word(CMD_PRIM_B, PRIM_DIV + PAY_W'(1));  // unknown code, first past divide
        send_word(CMD_PRIM_A, PRIM_ADD);
        send_word(CMD_PUSH_B, PAY_MAX);
        send_word(CMD_PRIM_B, PRIM_MUL);          // product wraps
        // most negative over minus one
        send_word(CMD_PUSH_A, 30'h2000_0000);
        send_word(CMD_PUSH_A, 30'd4);
        send_word(CMD_PRIM_A, PRIM_MUL);          // 0x80000000
        send_word(CMD_PUSH_B, '0);
        send_word(CMD_PUSH_B, 30'd1);
        send_word(CMD_PRIM_B, PRIM_SUB);          // minus one
        send_word(CMD_PRIM_A, PRIM_DIV);          // quotient wraps to 0x80000000
        // negative over positive truncates toward zero
        send_word(CMD_PUSH_A, '0);
        send_word(CMD_PUSH_A, 30'd7);
        send_word(CMD_PRIM_A, PRIM_SUB);
        send_word(CMD_PUSH_B, 30'd2);
        send_word(CMD_PRIM_B, PRIM_DIV);          // -3

        run_random(400);

        // long receiver hold-off: the block fills and stalls its input
        quiet_mode   = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 30; i++)
            send_random_word(MIX_EVEN);
        quiet_mode = 1'b0;
        wait_drained();

        // fill to the top and push past it
        for (int i = 0; i < 260; i++)
            send_word(push_header(), rand_operand());

        run_random(1060);

        // halt, then words that must be ignored
        send_word(CMD_PRIM_B, PRIM_HALT);
        send_word(CMD_PUSH_A, PAY_MAX);
        send_word(CMD_PRIM_A, PRIM_ADD);
        send_word(CMD_PRIM_B, PRIM_DIV);
        send_word(CMD_PRIM_A, PAY_MAX);
        send_word(CMD_PRIM_A, PRIM_HALT);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
